// ===== rtl/bfsp_pkg.sv =====
// Package for the Bellman-Ford shortest path block.
// Holds command codes, fixed field widths and parameter defaults.
// No dependencies; imported by the top level and by its checker.
`default_nettype none

package bfsp_pkg;

	// Parameter defaults.
	localparam int MAX_VERTICES_DEF  = 64;
	localparam int EDGE_CAPACITY_DEF = 256;
	localparam int WEIGHT_BITS_DEF   = 16;

	// Fixed field widths of the interface.
	localparam int VERTEX_BITS = 6;
	localparam int VCOUNT_BITS = 7;
	localparam int DIST_BITS   = 32;

	// Reset value of the vertex count register.
	localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd6;

	// Request commands.
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_RUN    = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bfsp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
`default_nettype none

module bfsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/bellman_ford_shortest_paths.sv =====
// Top level of the Bellman-Ford single-source shortest path block.
// Depends on bfsp_pkg and bfsp_ram (edge table and distance store).
//
// Usage: a request is taken when start is high and busy is low. Clear and
// append requests leave busy low, so edges load one per cycle. A run
// request raises busy until its last result is issued. A run makes as many
// passes over the stored edges as the effective vertex count (one checking
// pass and all others relaxing). Each stored edge is read in ST_EDGE_RD and
// checked in ST_EDGE_CHK, where it is skipped if it lies outside the graph
// or its tail is not yet reached; else it goes on through ST_SUM and ST_CMP,
// since the edge table read, the tail distance read and the head distance
// read go through registered memory ports in turn. Results then follow, one
// per vertex, each read from the distance store in ST_OUT_RD and issued in
// ST_OUT_EMIT. A negative cycle ends the checking pass at once with a single
// flagged result. Each result is shown for exactly one cycle while
// result_strobe is high; the receiver cannot stall it. Write vertex_count
// only while no run is in progress.
`default_nettype none

module bellman_ford_shortest_paths
	import bfsp_pkg::*;
#(
	parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
	parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration
	input  wire logic                   cfg_we,
	input  wire logic [VCOUNT_BITS-1:0] cfg_wdata,
	// Request
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             cmd,
	input  wire logic [VERTEX_BITS-1:0] source_vertex,
	input  wire logic [VERTEX_BITS-1:0] edge_from,
	input  wire logic [VERTEX_BITS-1:0] edge_to,
	input  wire logic [WEIGHT_BITS-1:0] edge_weight,
	// Result
	output logic                        result_strobe,
	output logic [VERTEX_BITS-1:0]      vertex,
	output logic [DIST_BITS-1:0]        distance,
	output logic                        reachable,
	output logic                        negative_cycle,
	output logic                        last
);

	localparam int VW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EAW    = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
	localparam int ECW    = $clog2(EDGE_CAPACITY + 1);
	localparam int EDGE_W = 2 * VERTEX_BITS + WEIGHT_BITS;
	localparam int SUM_W  = DIST_BITS + 1;

	localparam logic [VCOUNT_BITS-1:0] NV_MAX = VCOUNT_BITS'(MAX_VERTICES);
	localparam logic [ECW-1:0]         ECAP   = ECW'(EDGE_CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_RD,
		ST_EDGE_CHK,
		ST_SUM,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT_EMIT
	} state_t;

	state_t                   state_q;
	logic [VCOUNT_BITS-1:0]   vcount_q;
	logic [VCOUNT_BITS-1:0]   nv_q;
	logic [VCOUNT_BITS-1:0]   pass_q;
	logic [ECW-1:0]           ecount_q;
	logic [ECW-1:0]           edge_q;
	logic [MAX_VERTICES-1:0]  reached_q;
	logic [VW-1:0]            out_idx_q;
	logic [VERTEX_BITS-1:0]   v_q;
	logic [WEIGHT_BITS-1:0]   w_q;
	logic [DIST_BITS-1:0]     sum_q;

	logic                     accept;
	logic [VCOUNT_BITS-1:0]   nv;
	logic                     src_in;
	logic                     checking;

	logic                     edge_we;
	logic [EDGE_W-1:0]        edge_wdata;
	logic [EDGE_W-1:0]        edge_rdata;
	logic [VERTEX_BITS-1:0]   rd_from;
	logic [VERTEX_BITS-1:0]   rd_to;
	logic [WEIGHT_BITS-1:0]   rd_weight;
	logic                     edge_live;

	logic                     dist_we;
	logic [VW-1:0]            dist_waddr;
	logic [DIST_BITS-1:0]     dist_wdata;
	logic [VW-1:0]            dist_raddr;
	logic [DIST_BITS-1:0]     dist_rdata;

	logic [SUM_W-1:0]         sum_wide;
	logic [DIST_BITS-1:0]     sum_sat;
	logic                     improves;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Effective vertex count: zero counts as one, large values clamp.
	always_comb begin
		if (vcount_q == '0) begin
			nv = VCOUNT_BITS'(1);
		end else if (vcount_q > NV_MAX) begin
			nv = NV_MAX;
		end else begin
			nv = vcount_q;
		end
	end

	assign src_in   = ({1'b0, source_vertex} < nv);
	assign checking = (pass_q == nv_q);

	// Edge table write on an append request that finds room.
	assign edge_we    = accept && (cmd == CMD_APPEND) && (ecount_q < ECAP);
	assign edge_wdata = {edge_from, edge_to, edge_weight};
	assign {rd_from, rd_to, rd_weight} = edge_rdata;

	bfsp_ram #(
		.WIDTH (EDGE_W),
		.DEPTH (EDGE_CAPACITY)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (ecount_q[EAW-1:0]),
		.wdata (edge_wdata),
		.raddr (edge_q[EAW-1:0]),
		.rdata (edge_rdata)
	);

	// An edge takes part only if both ends lie in the graph and the tail
	// has been reached.
	assign edge_live = ({1'b0, rd_from} < nv_q) && ({1'b0, rd_to} < nv_q) &&
		reached_q[rd_from[VW-1:0]];

	// Saturating sum of the tail distance and the edge weight.
	always_comb begin
		sum_wide = {dist_rdata[DIST_BITS-1], dist_rdata} +
			{{(SUM_W - WEIGHT_BITS){w_q[WEIGHT_BITS-1]}}, w_q};
		if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2]) begin
			sum_sat = sum_wide[SUM_W-1] ? {1'b1, {(DIST_BITS-1){1'b0}}}
				: {1'b0, {(DIST_BITS-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[DIST_BITS-1:0];
		end
	end

	// The head improves when it is unreached or the new sum is smaller.
	assign improves = !reached_q[v_q[VW-1:0]] ||
		($signed(sum_q) < $signed(dist_rdata));

	// Distance store ports: the source is seeded at the run request, heads
	// are written back in the compare step of a relaxing pass.
	always_comb begin
		dist_we    = 1'b0;
		dist_waddr = v_q[VW-1:0];
		dist_wdata = sum_q;
		if (state_q == ST_IDLE) begin
			dist_we    = accept && (cmd == CMD_RUN) && src_in;
			dist_waddr = source_vertex[VW-1:0];
			dist_wdata = '0;
		end else if (state_q == ST_CMP) begin
			dist_we = improves && !checking;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_EDGE_CHK: dist_raddr = rd_from[VW-1:0];
			ST_OUT_RD:   dist_raddr = out_idx_q;
			default:     dist_raddr = v_q[VW-1:0];
		endcase
	end

	bfsp_ram #(
		.WIDTH (DIST_BITS),
		.DEPTH (MAX_VERTICES)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	// Sequencer: request handling, passes over the edges, result output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vcount_q       <= VCOUNT_RESET;
			nv_q           <= '0;
			pass_q         <= '0;
			ecount_q       <= '0;
			edge_q         <= '0;
			reached_q      <= '0;
			out_idx_q      <= '0;
			v_q            <= '0;
			w_q            <= '0;
			sum_q          <= '0;
			result_strobe  <= 1'b0;
			vertex         <= '0;
			distance       <= '0;
			reachable      <= 1'b0;
			negative_cycle <= 1'b0;
			last           <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_CLEAR) begin
							ecount_q <= '0;
						end else if (cmd == CMD_APPEND) begin
							if (ecount_q < ECAP) begin
								ecount_q <= ecount_q + ECW'(1);
							end
						end else if (cmd == CMD_RUN) begin
							// Only the source starts out reached.
							reached_q <= src_in ?
								(MAX_VERTICES'(1) << source_vertex[VW-1:0]) : '0;
							nv_q    <= nv;
							pass_q  <= VCOUNT_BITS'(1);
							edge_q  <= '0;
							state_q <= ST_EDGE_RD;
						end
					end
				end
				ST_EDGE_RD: begin
					// End of a pass: start the next one or go to output.
					if (edge_q == ecount_q) begin
						if (checking) begin
							out_idx_q <= '0;
							state_q   <= ST_OUT_RD;
						end else begin
							pass_q <= pass_q + VCOUNT_BITS'(1);
							edge_q <= '0;
						end
					end else begin
						state_q <= ST_EDGE_CHK;
					end
				end
				ST_EDGE_CHK: begin
					v_q <= rd_to;
					w_q <= rd_weight;
					if (edge_live) begin
						state_q <= ST_SUM;
					end else begin
						edge_q  <= edge_q + ECW'(1);
						state_q <= ST_EDGE_RD;
					end
				end
				ST_SUM: begin
					sum_q   <= sum_sat;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (improves && checking) begin
						result_strobe  <= 1'b1;
						vertex         <= '0;
						distance       <= '0;
						reachable      <= 1'b0;
						negative_cycle <= 1'b1;
						last           <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						if (improves) begin
							reached_q[v_q[VW-1:0]] <= 1'b1;
						end
						edge_q  <= edge_q + ECW'(1);
						state_q <= ST_EDGE_RD;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_EMIT;
				end
				ST_OUT_EMIT: begin
					result_strobe  <= 1'b1;
					vertex         <= VERTEX_BITS'(out_idx_q);
					reachable      <= reached_q[out_idx_q];
					distance       <= reached_q[out_idx_q] ? dist_rdata : '0;
					negative_cycle <= 1'b0;
					if (VCOUNT_BITS'(out_idx_q) + VCOUNT_BITS'(1) == nv_q) begin
						last    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						last      <= 1'b0;
						out_idx_q <= out_idx_q + VW'(1);
						state_q   <= ST_OUT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bfsp_checker.sv =====
// Port-level assertions for the Bellman-Ford shortest path block.
// Depends on bfsp_pkg; bound to bellman_ford_shortest_paths below.
`default_nettype none

module bfsp_checker
	import bfsp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic [1:0]             cmd,
	input wire logic                   result_strobe,
	input wire logic [VERTEX_BITS-1:0] vertex,
	input wire logic [DIST_BITS-1:0]   distance,
	input wire logic                   reachable,
	input wire logic                   negative_cycle,
	input wire logic                   last
);

	// A run request always makes the block busy in the next cycle.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_RUN) |=> busy)
		else $error("run request did not raise busy");

	// Table requests leave the block free in the cycle after they are taken.
	a_table_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((cmd == CMD_CLEAR) || (cmd == CMD_APPEND)) |=> !busy)
		else $error("table request raised busy");

	// A flagged result is the only and final result of its run.
	a_neg_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && negative_cycle |->
			last && !reachable && (distance == '0) && (vertex == '0))
		else $error("negative cycle result malformed");

	// More results of the same run follow, so the block stays occupied.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("block free in the middle of a result burst");

	// An unreached vertex reports a zero distance.
	a_unreached_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !reachable |-> (distance == '0))
		else $error("unreached vertex with nonzero distance");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (.*);

`default_nettype wire
